### rtl/lpg_pkg.sv
// Shared types and constants of the line point generator.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

    localparam int COLOR_W = 16;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_POS  = 2'b01,
        DIR_NEG  = 2'b11
    } dir_t;

endpackage

`default_nettype wire

### rtl/lpg_front.sv
// Front end of the line point generator: accepts input beats and works out the
// per-axis direction, absolute delta and major length of a start command.
// Depends on lpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpg_front #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic                          s_tuser,
    input  wire logic [((4*COORD_BITS+lpg_pkg::COLOR_W+7)/8)*8-1:0] s_tdata,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [5*COORD_BITS+lpg_pkg::COLOR_W+4:0] q_wdata
);

    localparam int C = COORD_BITS;

    logic [C-1:0]                sx, sy, ex, ey;
    logic [lpg_pkg::COLOR_W-1:0] color;
    logic [C-1:0]                adx, ady, major;
    lpg_pkg::dir_t               dir_x, dir_y;
    lpg_pkg::opcode_t            op;

    assign sx    = s_tdata[C-1:0];
    assign sy    = s_tdata[2*C-1:C];
    assign ex    = s_tdata[3*C-1:2*C];
    assign ey    = s_tdata[4*C-1:3*C];
    assign color = s_tdata[4*C+lpg_pkg::COLOR_W-1:4*C];
    assign op    = lpg_pkg::opcode_t'(s_tuser);

    always_comb begin
        if (ex > sx) begin
            adx   = ex - sx;
            dir_x = lpg_pkg::DIR_POS;
        end else if (ex == sx) begin
            adx   = '0;
            dir_x = lpg_pkg::DIR_NONE;
        end else begin
            adx   = sx - ex;
            dir_x = lpg_pkg::DIR_NEG;
        end
        if (ey > sy) begin
            ady   = ey - sy;
            dir_y = lpg_pkg::DIR_POS;
        end else if (ey == sy) begin
            ady   = '0;
            dir_y = lpg_pkg::DIR_NONE;
        end else begin
            ady   = sy - ey;
            dir_y = lpg_pkg::DIR_NEG;
        end
        major = (adx > ady) ? adx : ady;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_wdata  = {color, dir_y, dir_x, major, ady, adx, sy, sx, op};

endmodule

`default_nettype wire

### rtl/lpg_cmd_queue.sv
// Two-entry command queue between the front end and the point stepper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lpg_cmd_queue #(
    parameter int DATA_W = 71
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] wdata,
    output logic                   full,
    input  wire logic              pop,
    output logic                   rvalid,
    output logic [DATA_W-1:0]      rdata
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg, count_next;

    assign full   = (count_reg == 2'd2);
    assign rvalid = (count_reg != 2'd0);
    assign rdata  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### rtl/lpg_back.sv
// Point stepper of the line point generator: holds the line state, runs the
// error accumulators and drives the registered output beat. Depends on lpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpg_back #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_valid,
    input  wire logic [5*COORD_BITS+lpg_pkg::COLOR_W+4:0] q_rdata,
    output logic                                    q_pop,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [COORD_BITS-1:0]                   m_x,
    output logic [COORD_BITS-1:0]                   m_y,
    output logic [lpg_pkg::COLOR_W-1:0]             m_color,
    output logic                                    m_tlast
);

    localparam int C = COORD_BITS;

    lpg_pkg::opcode_t            q_op;
    logic [C-1:0]                q_sx, q_sy, q_adx, q_ady, q_major;
    lpg_pkg::dir_t               q_dir_x, q_dir_y;
    logic [lpg_pkg::COLOR_W-1:0] q_color;

    assign q_op    = lpg_pkg::opcode_t'(q_rdata[0]);
    assign q_sx    = q_rdata[C:1];
    assign q_sy    = q_rdata[2*C:C+1];
    assign q_adx   = q_rdata[3*C:2*C+1];
    assign q_ady   = q_rdata[4*C:3*C+1];
    assign q_major = q_rdata[5*C:4*C+1];
    assign q_dir_x = lpg_pkg::dir_t'(q_rdata[5*C+2:5*C+1]);
    assign q_dir_y = lpg_pkg::dir_t'(q_rdata[5*C+4:5*C+3]);
    assign q_color = q_rdata[5*C+lpg_pkg::COLOR_W+4:5*C+5];

    logic                        active_reg;
    logic [C-1:0]                cur_x_reg, cur_y_reg, cur_x_next, cur_y_next;
    logic [C:0]                  err_x_reg, err_y_reg, err_x_next, err_y_next;
    logic [C-1:0]                adx_reg, ady_reg, major_reg;
    lpg_pkg::dir_t               dir_x_reg, dir_y_reg;
    logic [C:0]                  left_reg;
    logic [lpg_pkg::COLOR_W-1:0] color_reg;
    logic                        m_valid_reg;
    logic [C-1:0]                m_x_reg, m_y_reg;
    logic [lpg_pkg::COLOR_W-1:0] m_color_reg;
    logic                        m_last_reg;

    logic       is_start, do_emit, is_last;
    logic [C:0] sum_x, sum_y;

    assign is_start = (q_op == lpg_pkg::OP_START);
    assign q_pop    = q_valid && (is_start || !active_reg || !m_valid_reg || m_tready);
    assign do_emit  = q_pop && !is_start && active_reg;
    assign is_last  = (left_reg[C:1] == '0);

    always_comb begin
        sum_x      = err_x_reg + {1'b0, adx_reg};
        sum_y      = err_y_reg + {1'b0, ady_reg};
        err_x_next = sum_x;
        err_y_next = sum_y;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (sum_x > {1'b0, major_reg}) begin
            err_x_next = sum_x - {1'b0, major_reg};
            case (dir_x_reg)
                lpg_pkg::DIR_POS: cur_x_next = cur_x_reg + 1'b1;
                lpg_pkg::DIR_NEG: cur_x_next = cur_x_reg - 1'b1;
                default:          cur_x_next = cur_x_reg;
            endcase
        end
        if (sum_y > {1'b0, major_reg}) begin
            err_y_next = sum_y - {1'b0, major_reg};
            case (dir_y_reg)
                lpg_pkg::DIR_POS: cur_y_next = cur_y_reg + 1'b1;
                lpg_pkg::DIR_NEG: cur_y_next = cur_y_reg - 1'b1;
                default:          cur_y_next = cur_y_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop && is_start) begin
                active_reg <= 1'b1;
            end else if (do_emit && is_last) begin
                active_reg <= 1'b0;
            end
            if (do_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && is_start) begin
            cur_x_reg <= q_sx;
            cur_y_reg <= q_sy;
            err_x_reg <= '0;
            err_y_reg <= '0;
            adx_reg   <= q_adx;
            ady_reg   <= q_ady;
            major_reg <= q_major;
            dir_x_reg <= q_dir_x;
            dir_y_reg <= q_dir_y;
            left_reg  <= {1'b0, q_major} + 1'b1;
            color_reg <= q_color;
        end else if (do_emit) begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_x_reg <= err_x_next;
            err_y_reg <= err_y_next;
            left_reg  <= is_last ? '0 : left_reg - 1'b1;
        end
        if (do_emit) begin
            m_x_reg     <= cur_x_reg;
            m_y_reg     <= cur_y_reg;
            m_color_reg <= color_reg;
            m_last_reg  <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_x      = m_x_reg;
    assign m_y      = m_y_reg;
    assign m_color  = m_color_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

### rtl/line_point_generator.sv
// Line point generator: a start beat loads a line, each step beat returns one point.
// A step beat's point reaches m_tdata through the command queue and then the registered output beat.
// Throughput: one beat per cycle on both sides while m_tready stays high, set by the point stepper.
// Start beats and steps without an active line give no output beat.
// Reset (aresetn low, synchronous) empties the command queue, drops the active line
// and clears the output valid.
`timescale 1ns / 1ps
`default_nettype none

module line_point_generator #(
    parameter int COORD_BITS = 10
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // opcode
    input  wire logic s_tuser,
    // start_x, start_y, end_x, end_y, pixel_color, zero padding
    input  wire logic [((4*COORD_BITS+lpg_pkg::COLOR_W+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // point_x, point_y, point_color, zero padding
    output logic [((2*COORD_BITS+lpg_pkg::COLOR_W+7)/8)*8-1:0] m_tdata,
    // last_point
    output logic      m_tlast
);

    localparam int Q_W   = 5*COORD_BITS + lpg_pkg::COLOR_W + 5;
    localparam int OUT_W = ((2*COORD_BITS + lpg_pkg::COLOR_W + 7) / 8) * 8;

    logic                        q_full, q_push, q_pop, q_valid;
    logic [Q_W-1:0]              q_wdata, q_rdata;
    logic [COORD_BITS-1:0]       m_x, m_y;
    logic [lpg_pkg::COLOR_W-1:0] m_color;

    lpg_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    lpg_cmd_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    lpg_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_x     (m_x),
        .m_y     (m_y),
        .m_color (m_color),
        .m_tlast (m_tlast)
    );

    assign m_tdata = OUT_W'({m_color, m_y, m_x});

endmodule

`default_nettype wire

### tb/line_point_checker.sv
// Checker for the line point generator: watches both stream channels, traces each line
// with its own error-accumulator stepper and compares every point beat field by field.
// Depends on lpg_pkg for the opcode and direction codes.
`timescale 1ns / 1ps

module line_point_checker #(
    parameter int COORD_BITS = 10,
    parameter int S_W = 56,
    parameter int M_W = 40
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           s_tready,
    input  wire logic           s_tuser,
    input  wire logic [S_W-1:0] s_tdata,
    input  wire logic           m_tvalid,
    input  wire logic           m_tready,
    input  wire logic [M_W-1:0] m_tdata,
    input  wire logic           m_tlast,
    output int                  mismatch_count,
    output int                  owed_count
);

    localparam int CB = COORD_BITS;
    localparam int CW = lpg_pkg::COLOR_W;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CW-1:0] color;
        logic          last;
    } point_t;

    point_t owed_points[$];

    logic          line_on;
    logic [CB-1:0] cur_x, cur_y;
    logic [CB:0]   err_x, err_y;
    logic [CB-1:0] mag_x, mag_y;
    lpg_pkg::dir_t dir_x, dir_y;
    logic [CB-1:0] major_len;
    logic [CB:0]   points_left;
    logic [CW-1:0] line_color;

    task automatic axis_setup(input logic [CB-1:0] from, input logic [CB-1:0] to,
                              output logic [CB-1:0] mag, output lpg_pkg::dir_t dir);
        if (to > from) begin
            mag = to - from;
            dir = lpg_pkg::DIR_POS;
        end else if (to == from) begin
            mag = '0;
            dir = lpg_pkg::DIR_NONE;
        end else begin
            mag = from - to;
            dir = lpg_pkg::DIR_NEG;
        end
    endtask

    function automatic logic [CB-1:0] axis_move(input logic [CB-1:0] pos,
                                                input lpg_pkg::dir_t dir);
        case (dir)
            lpg_pkg::DIR_POS: return pos + 1'b1;
            lpg_pkg::DIR_NEG: return pos - 1'b1;
            default:          return pos;
        endcase
    endfunction

    always @(posedge aclk) begin
        point_t want;
        point_t got;
        if (!aresetn) begin
            line_on = 1'b0;
            cur_x = '0;
            cur_y = '0;
            err_x = '0;
            err_y = '0;
            mag_x = '0;
            mag_y = '0;
            dir_x = lpg_pkg::DIR_NONE;
            dir_y = lpg_pkg::DIR_NONE;
            major_len = '0;
            points_left = '0;
            line_color = '0;
            owed_points.delete();
            mismatch_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser == lpg_pkg::OP_START) begin
                    axis_setup(s_tdata[CB-1:0], s_tdata[3*CB-1:2*CB], mag_x, dir_x);
                    axis_setup(s_tdata[2*CB-1:CB], s_tdata[4*CB-1:3*CB], mag_y, dir_y);
                    major_len = (mag_x > mag_y) ? mag_x : mag_y;
                    cur_x = s_tdata[CB-1:0];
                    cur_y = s_tdata[2*CB-1:CB];
                    err_x = '0;
                    err_y = '0;
                    points_left = {1'b0, major_len} + 1'b1;
                    line_color = s_tdata[4*CB+CW-1:4*CB];
                    line_on = 1'b1;
                end else if (line_on) begin
                    want.x = cur_x;
                    want.y = cur_y;
                    want.color = line_color;
                    want.last = (points_left <= 1);
                    owed_points.push_back(want);
                    err_x = err_x + {1'b0, mag_x};
                    err_y = err_y + {1'b0, mag_y};
                    if (err_x > {1'b0, major_len}) begin
                        err_x = err_x - {1'b0, major_len};
                        cur_x = axis_move(cur_x, dir_x);
                    end
                    if (err_y > {1'b0, major_len}) begin
                        err_y = err_y - {1'b0, major_len};
                        cur_y = axis_move(cur_y, dir_y);
                    end
                    if (points_left <= 1) begin
                        points_left = '0;
                        line_on = 1'b0;
                    end else begin
                        points_left = points_left - 1'b1;
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got.x = m_tdata[CB-1:0];
                got.y = m_tdata[2*CB-1:CB];
                got.color = m_tdata[2*CB+CW-1:2*CB];
                got.last = m_tlast;
                if (owed_points.size() == 0) begin
                    $error("point beat with none expected: x %0d y %0d", got.x, got.y);
                    mismatch_count++;
                end else begin
                    want = owed_points.pop_front();
                    if (got.x !== want.x) begin
                        $error("point_x: expected %0d, got %0d", want.x, got.x);
                        mismatch_count++;
                    end
                    if (got.y !== want.y) begin
                        $error("point_y: expected %0d, got %0d", want.y, got.y);
                        mismatch_count++;
                    end
                    if (got.color !== want.color) begin
                        $error("point_color: expected %h, got %h", want.color, got.color);
                        mismatch_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_point: expected %b, got %b", want.last, got.last);
                        mismatch_count++;
                    end
                end
            end
        end
        owed_count = owed_points.size();
    end

endmodule

### tb/tb_line_point_generator.sv
// Top of the line point generator testbench: clock, reset, directed and random line beats,
// randomized idling on both channels and the final verdict.
// Depends on lpg_pkg, line_point_generator and line_point_checker.
`timescale 1ns / 1ps

module tb_line_point_generator;

    localparam int CB = 10;
    localparam int CW = lpg_pkg::COLOR_W;
    localparam int S_W = ((4*CB+CW+7)/8)*8;
    localparam int M_W = ((2*CB+CW+7)/8)*8;
    localparam int MAX_C = (1 << CB) - 1;
    localparam int RANDOM_BEATS = 2000;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic           s_tuser;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;
    logic           m_tlast;

    int mismatch_count;
    int owed_count;
    int beats_sent = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    line_point_generator #(.COORD_BITS(CB)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    line_point_checker #(.COORD_BITS(CB), .S_W(S_W), .M_W(M_W)) checker_i (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .mismatch_count(mismatch_count),
        .owed_count(owed_count)
    );

    // The receiver holds off once for a long stretch so that the block backs up.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_beat(input lpg_pkg::opcode_t op, input logic [S_W-1:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        beats_sent++;
    endtask

    task automatic send_start(input int sx, input int sy, input int ex, input int ey,
                              input int color);
        logic [S_W-1:0] data;
        data = '0;
        data[CB-1:0] = CB'(sx);
        data[2*CB-1:CB] = CB'(sy);
        data[3*CB-1:2*CB] = CB'(ex);
        data[4*CB-1:3*CB] = CB'(ey);
        data[4*CB+CW-1:4*CB] = CW'(color);
        send_beat(lpg_pkg::OP_START, data);
    endtask

    task automatic send_steps(input int count);
        logic [S_W-1:0] junk;
        for (int i = 0; i < count; i++) begin
            junk = S_W'({$urandom, $urandom});
            send_beat(lpg_pkg::OP_STEP, junk);
        end
    endtask

    task automatic random_line();
        int span, sx, sy, ex, ey, len, pick;
        span = ($urandom_range(99) == 0) ? MAX_C : $urandom_range(15);
        sx = $urandom_range(MAX_C);
        sy = $urandom_range(MAX_C);
        ex = sx + $urandom_range(2*span) - span;
        ey = sy + $urandom_range(2*span) - span;
        ex = (ex < 0) ? 0 : (ex > MAX_C) ? MAX_C : ex;
        ey = (ey < 0) ? 0 : (ey > MAX_C) ? MAX_C : ey;
        len = ((ex > sx) ? ex - sx : sx - ex);
        len = ((ey > sy) ? ey - sy : sy - ey) > len ? ((ey > sy) ? ey - sy : sy - ey) : len;
        send_start(sx, sy, ex, ey, $urandom_range(16'hFFFF));
        pick = $urandom_range(99);
        if (pick < 80) begin
            send_steps(len + 1);
        end else if (pick < 90) begin
            send_steps($urandom_range(len));
        end else begin
            send_steps(len + 1 + $urandom_range(3));
        end
    endtask

    initial begin
        int phase;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = lpg_pkg::OP_START;
        s_tdata = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_steps(1);
        send_start(5, 5, 5, 5, 16'h1234);
        send_steps(2);
        send_start(0, 0, 3, 1, 16'h0000);
        send_steps(4);
        send_start(MAX_C, MAX_C, MAX_C - 3, MAX_C - 1, 16'hFFFF);
        send_steps(4);
        send_start(MAX_C, 0, MAX_C - 2, 3, 16'hA5A5);
        send_steps(4);
        send_start(10, 20, 10, 17, 16'h5A5A);
        send_steps(2);
        send_start(0, MAX_C, 1, MAX_C, 16'h0F0F);
        send_steps(2);

        while (beats_sent < 25 + RANDOM_BEATS) begin
            phase = (beats_sent / 200) % 5;
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 79;
                    recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 79;
                end
                3: begin
                    sender_idle_pct = 32;
                    recv_stall_pct = 32;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_req = 1'b1;
                end
            endcase
            if (beats_sent >= 1000) begin
                hold_req = 1'b1;
            end
            random_line();
        end

        s_tvalid <= 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        while (owed_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
